>>> sv/scu_pkg.sv
// ---------------------------------------------------------------------------
// scu_pkg
// Shared types and constants for the sine/cosine pipeline.
// ---------------------------------------------------------------------------
package scu_pkg;

    // 2/pi in unsigned Q0.32.
    localparam logic [31:0] TWO_OVER_PI = 32'hA2F9836E;

    // One in Q1.30.
    localparam logic [31:0] ONE30 = 32'h4000_0000;

    // Initial Horner terms, in units of 2^-30 like the step coefficients.
    localparam logic signed [32:0] CP_TOP = 33'sd18684;
    localparam logic signed [32:0] CQ_TOP = 33'sd128;

    // Coefficients that the four Horner steps add, in step order.
    localparam logic signed [32:0] CP_TAB [4] = '{-33'sd1772451, 33'sd56333191,
                                                  -33'sd632692237, 33'sd1738091645};
    localparam logic signed [32:0] CQ_TAB [4] = '{33'sd16980, 33'sd1211276,
                                                  33'sd52246941, 33'sd1106503508};

    localparam int POLY_STEPS = 4;
    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS   = 4;

    // Word passed between the polynomial stages.
    typedef struct packed {
        logic [30:0]        s;
        logic [30:0]        an;
        logic               yneg;
        logic signed [32:0] ps;
        logic signed [32:0] qs;
    } scu_poly_t;

    // Word passed between the divider stages.
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] nlo;
        logic [32:0] d;
        logic [31:0] q;
        logic        neg;
    } scu_div_t;

endpackage

>>> sv/sine_cosine_unit.sv
// ---------------------------------------------------------------------------
// sine_cosine_unit
// Fixed-point sine and cosine by a rational approximation, fully pipelined.
// ---------------------------------------------------------------------------
// The unit takes one word per cycle and returns the results in order: two
// stages reduce the angle, four stages evaluate the numerator and denominator
// polynomials side by side, one stage forms the dividend that rounds to
// nearest, eight stages divide four quotient bits each, and one output
// register saturates and signs the value. The whole pipeline moves together
// and halts only while a finished result is not taken.
module sine_cosine_unit
    import scu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] angle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value
);

    logic              en;
    logic              pv [POLY_STEPS+1];
    scu_poly_t         pd [POLY_STEPS+1];
    logic              dv [DIV_STAGES+1];
    scu_div_t          dd [DIV_STAGES+1];
    logic [31:0]       pmag;
    logic [62:0]       num;
    logic [63:0]       dvd;
    scu_div_t          div0_next;
    logic              dv0_reg;
    scu_div_t          div0_reg;
    logic [31:0]       qsat;
    logic              out_valid_reg;
    logic [31:0]       value_reg;
    logic [31:0]       value_next;

    // The pipeline advances whenever the output register is free or its word is taken.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    scu_reduce u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vin   (in_valid),
        .cmd   (cmd),
        .angle (angle),
        .vout  (pv[0]),
        .dout  (pd[0])
    );

    // Horner stages.
    for (genvar g = 0; g < POLY_STEPS; g++)
    begin : g_poly
        scu_poly_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vin   (pv[g]),
            .din   (pd[g]),
            .cp    (CP_TAB[g]),
            .cq    (CQ_TAB[g]),
            .vout  (pv[g+1]),
            .dout  (pd[g+1])
        );
    end

    // Dividend 2*|P|*|y| + Q and divisor 2*Q for rounding to nearest.
    always_comb
    begin
        pmag = pd[POLY_STEPS].ps[32] ? 32'(-pd[POLY_STEPS].ps) : 32'(pd[POLY_STEPS].ps);
        num  = {31'd0, pmag} * {32'd0, pd[POLY_STEPS].an};
        dvd  = {num, 1'b0} + {31'd0, pd[POLY_STEPS].qs};
        div0_next.rem = {2'b00, dvd[63:32]};
        div0_next.nlo = dvd[31:0];
        div0_next.d   = {pd[POLY_STEPS].qs[31:0], 1'b0};
        div0_next.q   = '0;
        div0_next.neg = pd[POLY_STEPS].ps[32] ^ pd[POLY_STEPS].yneg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv0_reg <= 1'b0;
        end
        else if (en)
        begin
            dv0_reg <= pv[POLY_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div0_reg <= div0_next;
        end
    end

    assign dv[0] = dv0_reg;
    assign dd[0] = div0_reg;

    // Divider stages.
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        scu_div_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vin   (dv[g]),
            .din   (dd[g]),
            .vout  (dv[g+1]),
            .dout  (dd[g+1])
        );
    end

    // Saturate to one and apply the sign.
    always_comb
    begin
        qsat       = (dd[DIV_STAGES].q > ONE30) ? ONE30 : dd[DIV_STAGES].q;
        value_next = dd[DIV_STAGES].neg ? (32'd0 - qsat) : qsat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    // A delivered word stays within plus or minus one.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(value) <= 32'sh4000_0000 &&
                       $signed(value) >= -32'sh4000_0000))
        else $error("result outside plus or minus one");

    // A stalled output stays valid, and in the next cycle in_ready follows out_ready.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && (in_ready == out_ready)))
        else $error("stall did not reach the input");

endmodule

>>> sv/scu_reduce.sv
// ---------------------------------------------------------------------------
// scu_reduce
// Argument reduction: scales the angle by 2/pi, folds it into one quadrant
// and squares the folded fraction. Two register stages.
// ---------------------------------------------------------------------------
module scu_reduce
    import scu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vin,
    input  logic             cmd,
    input  logic [31:0]      angle,
    output logic             vout,
    output scu_poly_t        dout
);

    logic [31:0] mag;
    logic [1:0]  base;
    logic [63:0] prod;
    logic        v1_reg;
    logic [31:0] x_reg;
    logic [1:0]  base_reg;
    logic [1:0]  quad;
    logic [29:0] f;
    logic [30:0] yabs;
    logic [61:0] sq;
    logic        vout_reg;
    scu_poly_t   dout_next;
    scu_poly_t   dout_reg;

    // Magnitude and starting quadrant; cosine ignores the sign.
    always_comb
    begin
        mag  = angle[31] ? (32'd0 - angle) : angle;
        base = cmd ? 2'd1 : (angle[31] ? 2'd2 : 2'd0);
        prod = {32'd0, mag} * {32'd0, TWO_OVER_PI};
    end

    // Stage one keeps the quadrant bits and the fraction of the scaled angle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= prod[57:26];
            base_reg <= base;
        end
    end

    // Fold the fraction into the quadrant and square it.
    always_comb
    begin
        quad = base_reg + x_reg[31:30];
        f    = x_reg[29:0];
        yabs = quad[0] ? (31'h4000_0000 - {1'b0, f}) : {1'b0, f};
        sq   = {31'd0, yabs} * {31'd0, yabs};
        dout_next.s    = sq[60:30];
        dout_next.an   = yabs;
        dout_next.yneg = quad[1];
        dout_next.ps   = CP_TOP;
        dout_next.qs   = CQ_TOP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            vout_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign vout = vout_reg;
    assign dout = dout_reg;

endmodule

>>> sv/scu_poly_step.sv
// ---------------------------------------------------------------------------
// scu_poly_step
// One Horner step for both numerator and denominator polynomials.
// ---------------------------------------------------------------------------
module scu_poly_step
    import scu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vin,
    input  scu_poly_t          din,
    input  logic signed [32:0] cp,
    input  logic signed [32:0] cq,
    output logic               vout,
    output scu_poly_t          dout
);

    logic signed [64:0] pm;
    logic signed [64:0] qm;
    scu_poly_t          dout_next;
    scu_poly_t          dout_reg;
    logic               vout_reg;

    // t = floor(t * s / 2^30) + c; the arithmetic shift rounds toward minus infinity.
    always_comb
    begin
        pm = 65'(din.ps) * $signed({34'd0, din.s});
        qm = 65'(din.qs) * $signed({34'd0, din.s});
        dout_next    = din;
        dout_next.ps = 33'(pm >>> 30) + cp;
        dout_next.qs = 33'(qm >>> 30) + cq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            vout_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign vout = vout_reg;
    assign dout = dout_reg;

endmodule

>>> sv/scu_div_step.sv
// ---------------------------------------------------------------------------
// scu_div_step
// Four restoring-division steps of the quotient, one register stage.
// ---------------------------------------------------------------------------
module scu_div_step
    import scu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      vin,
    input  scu_div_t  din,
    output logic      vout,
    output scu_div_t  dout
);

    scu_div_t dout_next;
    scu_div_t dout_reg;
    logic     vout_reg;

    // Shift in one dividend bit, then subtract the divisor when it fits.
    always_comb
    begin
        dout_next = din;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            dout_next.rem = {dout_next.rem[32:0], dout_next.nlo[31]};
            dout_next.nlo = {dout_next.nlo[30:0], 1'b0};
            if (dout_next.rem >= {1'b0, dout_next.d})
            begin
                dout_next.rem = dout_next.rem - {1'b0, dout_next.d};
                dout_next.q   = {dout_next.q[30:0], 1'b1};
            end
            else
            begin
                dout_next.q   = {dout_next.q[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            vout_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign vout = vout_reg;
    assign dout = dout_reg;

endmodule
